FILE: hw/rtl/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types, codes and frame word helpers for the SPI register access master
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

  localparam int unsigned FRAME_BITS_DEF = 16;
  localparam int unsigned WORD_BITS      = 16;

  // configuration register reset values
  localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [15:0] SETTLE_RST      = 16'd10;

  // configuration register indexes
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_SETTLE      = 1'b1;

  // request modes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // targets
  localparam logic DEV_ADC = 1'b0;
  localparam logic DEV_DAC = 1'b1;

  // fixed frame words of the adc readout sequence, and the dac read flag
  localparam logic [15:0] ADC_RDOUT_EN  = 16'h0001;
  localparam logic [15:0] ADC_RDOUT_DIS = 16'h0000;
  localparam logic [15:0] DAC_READ_FLAG = 16'h8000;

  typedef struct packed {
    logic [1:0] mode;
    logic       device;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic       adc_sdo;
    logic       dac_sdo;
  } req_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [15:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic       sclk;
    logic       mosi;
    logic       adc_sel_n;
    logic       dac_sel_n;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } res_t;

  // first word of a request
  function automatic logic [15:0] first_word(input logic dev, input logic rd,
                                             input logic [7:0] a, input logic [7:0] wd);
    logic [15:0] w;
    if (dev == DEV_DAC) begin
      if (rd) w = DAC_READ_FLAG | {3'b000, a[4:0], 8'h00};
      else    w = {3'b000, a[4:0], wd};
    end else begin
      if (rd) w = ADC_RDOUT_EN;
      else    w = {a, wd};
    end
    return w;
  endfunction

  // frames of the three-frame adc read
  function automatic logic [15:0] adc_read_word(input logic [1:0] idx, input logic [7:0] a);
    logic [15:0] w;
    if (idx == 2'd0)      w = ADC_RDOUT_EN;
    else if (idx == 2'd1) w = {a, 8'h00};
    else                  w = ADC_RDOUT_DIS;
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sra_seq.sv
// ----------------------------------------------------------------------------
// sra_seq
// Pin sequencer: one tick per step, frame phases, bit shifting and sampling
// ----------------------------------------------------------------------------
`default_nettype none

module sra_seq
  import sra_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  step,
  input  req_t req,
  input  cfg_t cfg,
  output res_t res
);

  localparam int unsigned BW = $clog2(FRAME_BITS + 1);

  typedef enum logic [2:0] {
    PH_IDLE, PH_PRE, PH_SETUP, PH_BITA, PH_BITB, PH_HOLD, PH_SETTLE
  } phase_t;

  phase_t        phase_r,     phase_nxt;
  logic [15:0]   tick_r,      tick_nxt;
  logic [BW-1:0] bit_cnt_r,   bit_cnt_nxt;
  logic [15:0]   tx_r,        tx_nxt;
  logic [7:0]    rx_r,        rx_nxt;
  logic [1:0]    frame_r,     frame_nxt;
  logic          dev_r,       dev_nxt;
  logic          read_r,      read_nxt;
  logic [7:0]    addr_r,      addr_nxt;
  logic [7:0]    last_read_r, last_read_nxt;

  always_comb begin
    logic        cpol;
    logic [15:0] dur;
    logic [16:0] tick_inc;
    logic [5:0]  bit_ext;
    logic        sdo;
    logic        next_frame;
    logic        fin;

    phase_nxt     = phase_r;
    tick_nxt      = tick_r;
    bit_cnt_nxt   = bit_cnt_r;
    tx_nxt        = tx_r;
    rx_nxt        = rx_r;
    frame_nxt     = frame_r;
    dev_nxt       = dev_r;
    read_nxt      = read_r;
    addr_nxt      = addr_r;
    last_read_nxt = last_read_r;
    fin           = 1'b0;
    next_frame    = 1'b0;
    cpol          = 1'b0;
    dur           = 16'd1;
    tick_inc      = 17'd0;
    bit_ext       = 6'd0;
    sdo           = 1'b0;
    res           = '0;
    res.adc_sel_n = 1'b1;
    res.dac_sel_n = 1'b1;

    // request start when idle
    if (phase_r == PH_IDLE && (req.mode == MODE_WRITE || req.mode == MODE_READ)) begin
      dev_nxt     = req.device;
      read_nxt    = (req.mode == MODE_READ);
      addr_nxt    = req.addr;
      frame_nxt   = 2'd0;
      tx_nxt      = first_word(req.device, (req.mode == MODE_READ), req.addr, req.wdata);
      rx_nxt      = 8'h00;
      bit_cnt_nxt = '0;
      tick_nxt    = 16'd0;
      phase_nxt   = PH_PRE;
    end

    if (phase_nxt != PH_IDLE) begin
      res.busy_res = 1'b1;
      cpol         = (dev_nxt == DEV_ADC);
      unique case (phase_nxt)
        PH_PRE: begin
          res.sclk = cpol;
        end
        PH_SETUP: begin
          res.sclk      = cpol;
          res.adc_sel_n = dev_nxt;
          res.dac_sel_n = ~dev_nxt;
        end
        PH_BITA: begin
          res.sclk      = cpol;
          res.mosi      = tx_nxt[15];
          res.adc_sel_n = dev_nxt;
          res.dac_sel_n = ~dev_nxt;
        end
        PH_BITB: begin
          res.sclk      = ~cpol;
          res.mosi      = tx_nxt[15];
          res.adc_sel_n = dev_nxt;
          res.dac_sel_n = ~dev_nxt;
        end
        PH_HOLD: begin
          res.sclk = cpol;
        end
        default: ;
      endcase

      if (phase_nxt == PH_SETTLE)              dur = cfg.settle_ticks;
      else if (cfg.half_period_ticks == 16'd0) dur = 16'd1;
      else                                     dur = cfg.half_period_ticks;

      tick_inc = {1'b0, tick_nxt} + 17'd1;
      if (tick_inc >= {1'b0, dur}) begin
        tick_nxt = 16'd0;
        unique case (phase_nxt)
          PH_PRE:   phase_nxt = PH_SETUP;
          PH_SETUP: phase_nxt = PH_BITA;
          PH_BITA:  phase_nxt = PH_BITB;
          PH_BITB: begin
            sdo     = (dev_nxt == DEV_DAC) ? req.dac_sdo : req.adc_sdo;
            bit_ext = 6'(bit_cnt_nxt);
            // frame bits 8 to 15 make up the data byte, msb first
            if (bit_ext[5:3] == 3'b001) rx_nxt[~bit_ext[2:0]] = sdo;
            tx_nxt      = {tx_nxt[14:0], 1'b0};
            bit_cnt_nxt = bit_cnt_nxt + 1'b1;
            if (bit_cnt_nxt >= BW'(FRAME_BITS)) begin
              if (read_nxt && (dev_nxt == DEV_DAC || frame_nxt == 2'd1))
                last_read_nxt = rx_nxt;
              phase_nxt = PH_HOLD;
            end else begin
              phase_nxt = PH_BITA;
            end
          end
          PH_HOLD: begin
            if (dev_nxt == DEV_ADC && read_nxt && frame_nxt != 2'd1 &&
                cfg.settle_ticks != 16'd0)
              phase_nxt = PH_SETTLE;
            else
              next_frame = 1'b1;
          end
          default: next_frame = 1'b1;
        endcase

        if (next_frame) begin
          if (dev_nxt == DEV_ADC && read_nxt && frame_nxt < 2'd2) begin
            frame_nxt   = frame_nxt + 2'd1;
            tx_nxt      = adc_read_word(frame_nxt, addr_nxt);
            rx_nxt      = 8'h00;
            bit_cnt_nxt = '0;
            phase_nxt   = PH_PRE;
          end else begin
            phase_nxt = PH_IDLE;
            fin       = 1'b1;
          end
        end
      end else begin
        tick_nxt = tick_inc[15:0];
      end
    end

    res.done_res  = fin;
    res.read_data = last_read_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= 16'd0;
      bit_cnt_r   <= '0;
      tx_r        <= 16'd0;
      rx_r        <= 8'h00;
      frame_r     <= 2'd0;
      dev_r       <= 1'b0;
      read_r      <= 1'b0;
      addr_r      <= 8'h00;
      last_read_r <= 8'h00;
    end else if (step) begin
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      tx_r        <= tx_nxt;
      rx_r        <= rx_nxt;
      frame_r     <= frame_nxt;
      dev_r       <= dev_nxt;
      read_r      <= read_nxt;
      addr_r      <= addr_nxt;
      last_read_r <= last_read_nxt;
    end
  end

  a_cs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (res.adc_sel_n || res.dac_sel_n))
    else $error("both chip selects asserted");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.done_res) |=> (phase_r == PH_IDLE))
    else $error("request finished but sequencer not idle");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_r == 16'd0))
    else $error("tick counter not cleared while idle");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= BW'(FRAME_BITS))
    else $error("bit counter beyond frame length");

endmodule

`default_nettype wire

FILE: hw/rtl/spi_register_access_master.sv
// ----------------------------------------------------------------------------
// spi_register_access_master
// SPI master for register access to an ADC (mode 2) and a DAC (mode 0)
// ----------------------------------------------------------------------------
//
//   channel | ports              | carries
//   --------+--------------------+-----------------------------------------
//   in      | in_tvalid/tready   | one sequencer tick with request and pins
//   out     | out_tvalid/tready  | pin levels and status for that tick
//   cfg     | cfg_wr_en/addr     | half period and settle gap registers
//
// every input transfer is one tick of the pin sequencer and yields exactly
// one output transfer; a tick is worked out in the cycle it is accepted and
// sits in the output register from the next cycle on
// a new tick is taken every cycle while the output register is empty or is
// being drained, so the rate is one transfer per cycle
// a stall on the output side holds the result and stops input transfers
// synchronous active-low reset returns the sequencer to idle and loads the
// register defaults (half period 5, settle 10)
//
`default_nettype none

module spi_register_access_master
  import sra_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  // input stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // mode[1:0] device[2] addr[10:3] wdata[18:11]
                                  // adc_sdo[19] dac_sdo[20], zero fill above
  // result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // sclk[0] mosi[1] adc_sel_n[2] dac_sel_n[3]
                                  // busy_res[4] done_res[5] read_data[13:6]
  // configuration writes
  input  wire         cfg_wr_en,
  input  wire         cfg_addr,
  input  wire  [15:0] cfg_wdata
);

  cfg_t cfg_r;
  req_t req;
  res_t res;
  res_t out_res_r;
  logic out_valid_r;
  logic in_xfer;

  // unpack the input transfer
  assign req.mode    = in_tdata[1:0];
  assign req.device  = in_tdata[2];
  assign req.addr    = in_tdata[10:3];
  assign req.wdata   = in_tdata[18:11];
  assign req.adc_sdo = in_tdata[19];
  assign req.dac_sdo = in_tdata[20];

  // output register frees up when drained in the same cycle
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // configuration registers; the user is to write them only while the sequencer is quiet, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= HALF_PERIOD_RST;
      cfg_r.settle_ticks      <= SETTLE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_HALF_PERIOD: cfg_r.half_period_ticks <= cfg_wdata;
        CFG_SETTLE:      cfg_r.settle_ticks      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sra_seq #(
    .FRAME_BITS (FRAME_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_xfer),
    .req   (req),
    .cfg   (cfg_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.read_data, out_res_r.done_res, out_res_r.busy_res,
                       out_res_r.dac_sel_n, out_res_r.adc_sel_n, out_res_r.mosi,
                       out_res_r.sclk};

endmodule

`default_nettype wire
